@@ design/lnf_pkg.sv @@
// Package for the leaky NLMS adaptive filter: command/status/config types,
// register indexes, mode and op codes and fixed arithmetic widths.
// No dependencies.
`default_nettype none
package lnf_pkg;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_NLMS = 2'd1;
  localparam logic [1:0] MODE_LMS  = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_REGUL = 2'd2;
  localparam logic [1:0] REG_LEAK  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0]  RST_MODE  = MODE_NLMS;
  localparam logic [5:0]  RST_STEP  = 6'd5;
  localparam logic [15:0] RST_REGUL = 16'd100;
  localparam logic [15:0] RST_LEAK  = 16'd0;

  localparam int X_W       = 24;
  localparam int CF_BITS   = 24;
  localparam int EN_W      = 40;
  localparam int DEN_W     = 41;
  localparam int MU_W      = 10;
  localparam int F_W       = 26;
  localparam int DIV_STEPS = 40;
  localparam int DIVC_W    = 6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  step_size;
    logic [15:0] regularizer;
    logic [15:0] leak_factor;
  } lnf_cfg_t;

  typedef struct packed {
    logic take_sample;
    logic take_pt;
    logic clear_coef;
    logic rd;
    logic p1_mul;
    logic p1_acc;
    logic fin;
    logic u_mul;
    logic u_mul2;
    logic div_start;
    logic u_wr;
    logic wp_adv;
    logic load_out;
  } lnf_cmd_t;

  typedef struct packed {
    logic adaptive;
    logic plain;
    logic div_busy;
    logic out_free;
  } lnf_status_t;

endpackage
`default_nettype wire

@@ design/lnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/lnf_ctrl.sv @@
// Sequencer of the leaky NLMS filter: steps the filter pass, the error
// step and the update pass over all taps. Uses lnf_pkg.
`default_nettype none
module lnf_ctrl import lnf_pkg::*; #(
  parameter int TAPS = 32,
  localparam int TW = $clog2(TAPS)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        op_i,
  output logic        in_stall_o,
  input  lnf_status_t status_i,
  output lnf_cmd_t    cmd_o,
  output logic [TW-1:0] idx_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P1_RD  = 4'd1;
  localparam logic [3:0] S_P1_MUL = 4'd2;
  localparam logic [3:0] S_P1_ACC = 4'd3;
  localparam logic [3:0] S_ERR    = 4'd4;
  localparam logic [3:0] S_U_RD   = 4'd5;
  localparam logic [3:0] S_U_MUL  = 4'd6;
  localparam logic [3:0] S_U_MUL2 = 4'd7;
  localparam logic [3:0] S_U_DIV  = 4'd8;
  localparam logic [3:0] S_U_WAIT = 4'd9;
  localparam logic [3:0] S_U_WR   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  localparam logic [TW-1:0] LAST = TW'(TAPS - 1);

  logic [3:0]    state_q, state_d;
  logic [TW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_CLEAR) begin
            cmd_o.clear_coef = 1'b1;
          end else if (status_i.adaptive) begin
            cmd_o.take_sample = 1'b1;
            cnt_d   = '0;
            state_d = S_P1_RD;
          end else begin
            cmd_o.take_pt = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_P1_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_P1_MUL;
      end
      S_P1_MUL: begin
        cmd_o.p1_mul = 1'b1;
        state_d      = S_P1_ACC;
      end
      S_P1_ACC: begin
        cmd_o.p1_acc = 1'b1;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = S_ERR;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_P1_RD;
        end
      end
      S_ERR: begin
        cmd_o.fin = 1'b1;
        state_d   = S_U_RD;
      end
      S_U_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_U_MUL;
      end
      S_U_MUL: begin
        cmd_o.u_mul = 1'b1;
        state_d     = S_U_MUL2;
      end
      S_U_MUL2: begin
        cmd_o.u_mul2 = 1'b1;
        state_d      = status_i.plain ? S_U_WR : S_U_DIV;
      end
      S_U_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_U_WAIT;
      end
      S_U_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_U_WR;
        end
      end
      S_U_WR: begin
        cmd_o.u_wr = 1'b1;
        if (cnt_q == LAST) begin
          cmd_o.wp_adv = 1'b1;
          state_d      = S_OUT;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_U_RD;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign idx_o      = cnt_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST) else $error("tap counter out of range");
  a_clear_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && op_i == OP_CLEAR) |=> state_q == S_IDLE)
    else $error("clear beat left idle");
`endif

endmodule
`default_nettype wire

@@ design/lnf_dp.sv @@
// Datapath of the leaky NLMS filter: tap line and coefficient memories,
// dot product, error, coefficient update with a bit-serial divider and
// the output register. Uses lnf_pkg and lnf_ram.
`default_nettype none
module lnf_dp import lnf_pkg::*; #(
  parameter int TAPS = 32,
  parameter int DELAY = 1,
  parameter int SAMPLE_BITS = 16,
  localparam int TW = $clog2(TAPS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lnf_cmd_t           cmd_i,
  input  logic [TW-1:0]      idx_i,
  input  lnf_cfg_t           cfg_i,
  input  logic signed [15:0] sample_i,
  input  logic               out_stall_i,
  output lnf_status_t        status_o,
  output logic               out_valid_o,
  output logic signed [15:0] error_out_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ALIGN = X_W - SAMPLE_BITS;
  localparam int RSH   = CF_BITS + ALIGN;
  localparam logic [TW-1:0] D_IDX = TW'(DELAY % TAPS);
  localparam logic [TW-1:0] LAST  = TW'(TAPS - 1);
  localparam logic signed [65:0] EHI = (66'sd1 <<< (SB - 1)) - 66'sd1;
  localparam logic signed [65:0] ELO = -EHI - 66'sd1;
  localparam logic signed [61:0] CMAX = 62'sd2147483647;
  localparam logic signed [61:0] CMIN = -62'sd2147483648;

  logic signed [SB-1:0] x_in;
  logic [TW-1:0]   wp_q;
  logic [TAPS-1:0] tap_valid_q, coef_valid_q;
  logic [TW:0]     diff;
  logic [TW-1:0]   tap_addr;
  logic [SB-1:0]   tap_rdata;
  logic [31:0]     coef_rdata;
  logic [TW-1:0]   ridx_q;
  logic            tvld_q, cvld_q;
  logic signed [SB-1:0] xr;
  logic signed [X_W-1:0] x24r, d24, e24;
  logic signed [31:0] w_r;
  logic signed [55:0] prod;
  logic signed [47:0] sq;
  logic [47:0]        sq_r;
  logic signed [55:0] prod_q;
  logic [31:0]        eterm_q;
  logic signed [63:0] acc_q;
  logic [EN_W-1:0]    en_q, we_q;
  logic signed [SB-1:0] d_q, eo_q, eo_d;
  logic signed [65:0] e66, er66;
  logic [MU_W-1:0]    mu, mu_q;
  logic [F_W-1:0]     f_q;
  logic signed [47:0] p_q;
  logic signed [58:0] fw_q, num_q, rfw;
  logic signed [31:0] w_q;
  logic signed [50:0] t3, rinc;
  logic signed [59:0] base_q;
  logic [DEN_W-1:0]   den;
  logic [58:0]        mag;
  logic               clamp;
  logic [41:0]        rem_q, rs;
  logic [39:0]        dvd_q, q_q;
  logic               ge;
  logic               clamp_q, neg_q;
  logic [DIVC_W-1:0]  dcnt_q;
  logic [40:0]        res;
  logic signed [41:0] delta;
  logic signed [61:0] nw;
  logic signed [31:0] nw32;
  logic               nlms;
  logic               out_valid_q;
  logic signed [15:0] err_q;
  logic signed [31:0] eo_ext;

  assign x_in = signed'(SB'(unsigned'(sample_i)));
  assign nlms = (cfg_i.mode == MODE_NLMS);

  always_comb begin
    diff = {1'b0, wp_q} - {1'b0, idx_i};
    if (wp_q >= idx_i) begin
      tap_addr = TW'(diff);
    end else begin
      tap_addr = TW'(diff + (TW + 1)'(TAPS));
    end
  end

  lnf_ram #(.WIDTH(SB), .DEPTH(TAPS)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take_sample),
    .waddr_i (wp_q),
    .wdata_i (unsigned'(x_in)),
    .re_i    (cmd_i.rd),
    .raddr_i (tap_addr),
    .rdata_o (tap_rdata)
  );

  lnf_ram #(.WIDTH(32), .DEPTH(TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.u_wr),
    .waddr_i (ridx_q),
    .wdata_i (unsigned'(nw32)),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_i),
    .rdata_o (coef_rdata)
  );

  assign xr   = tvld_q ? signed'(tap_rdata) : '0;
  assign x24r = X_W'(xr) <<< ALIGN;
  assign w_r  = cvld_q ? signed'(coef_rdata) : '0;
  assign d24  = X_W'(d_q) <<< ALIGN;
  assign e24  = X_W'(eo_q) <<< ALIGN;

  assign prod = w_r * x24r;
  assign sq   = x24r * x24r;
  assign sq_r = (unsigned'(sq) + 48'd32768) >> 16;

  always_comb begin
    e66  = (66'(d24) <<< CF_BITS) - 66'(acc_q);
    er66 = (e66 + (66'sd1 <<< (RSH - 1))) >>> RSH;
    if (er66 > EHI) begin
      eo_d = SB'(EHI);
    end else if (er66 < ELO) begin
      eo_d = SB'(ELO);
    end else begin
      eo_d = SB'(er66);
    end
  end

  assign mu   = MU_W'({cfg_i.step_size, 3'b000}) + MU_W'({cfg_i.step_size, 1'b0});
  assign rfw  = (fw_q + 59'sd32768) >>> 16;
  assign t3   = (51'(p_q) <<< 1) + 51'(p_q);
  assign rinc = (t3 + (51'sd1 <<< 22)) >>> 23;

  assign den   = DEN_W'(cfg_i.regularizer) + DEN_W'(we_q);
  assign mag   = num_q[58] ? unsigned'(-num_q) : unsigned'(num_q);
  assign clamp = 74'(mag) >= 74'({den, 32'd0});
  assign rs    = {rem_q[40:0], dvd_q[39]};
  assign ge    = rs >= {1'b0, den};
  assign res   = clamp_q ? (41'd1 << 40) : {1'b0, q_q};
  assign delta = neg_q ? -signed'({1'b0, res}) : signed'({1'b0, res});

  always_comb begin
    nw = 62'(base_q) + (nlms ? 62'(delta) : 62'sd0);
    if (nw > CMAX) begin
      nw32 = 32'(CMAX);
    end else if (nw < CMIN) begin
      nw32 = 32'(CMIN);
    end else begin
      nw32 = 32'(nw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      tap_valid_q  <= '0;
      coef_valid_q <= '0;
      dcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.take_sample) begin
        tap_valid_q[wp_q] <= 1'b1;
      end
      if (cmd_i.wp_adv) begin
        wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
      end
      if (cmd_i.clear_coef) begin
        coef_valid_q <= '0;
      end else if (cmd_i.u_wr) begin
        coef_valid_q[ridx_q] <= 1'b1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= (den == '0 || clamp) ? '0 : DIVC_W'(DIV_STEPS);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign eo_ext = 32'(eo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      ridx_q <= idx_i;
      tvld_q <= tap_valid_q[tap_addr];
      cvld_q <= coef_valid_q[idx_i];
    end
    if (cmd_i.take_sample) begin
      acc_q <= '0;
      en_q  <= '0;
    end else if (cmd_i.p1_acc) begin
      acc_q <= acc_q + 64'(prod_q);
      en_q  <= en_q + EN_W'(eterm_q);
    end
    if (cmd_i.p1_mul) begin
      prod_q  <= prod;
      eterm_q <= 32'(sq_r);
      if (ridx_q == D_IDX) begin
        d_q <= xr;
      end
    end
    if (cmd_i.take_pt) begin
      eo_q <= x_in;
    end else if (cmd_i.fin) begin
      eo_q <= eo_d;
    end
    if (cmd_i.fin) begin
      we_q <= en_q;
      mu_q <= mu;
      f_q  <= F_W'(mu) * F_W'(cfg_i.leak_factor);
    end
    if (cmd_i.u_mul) begin
      p_q  <= x24r * e24;
      fw_q <= 59'(signed'({1'b0, f_q})) * 59'(w_r);
      w_q  <= w_r;
    end
    if (cmd_i.u_mul2) begin
      num_q <= 59'(signed'({1'b0, mu_q})) * 59'(p_q);
      if (nlms) begin
        base_q <= 60'(w_q) - 60'(rfw);
      end else begin
        base_q <= 60'(w_q) + 60'(rinc);
      end
    end
    if (cmd_i.div_start) begin
      neg_q   <= num_q[58];
      clamp_q <= (den != '0) && clamp;
      q_q     <= '0;
      rem_q   <= 42'(mag >> 32);
      dvd_q   <= {mag[31:0], 8'd0};
    end else if (dcnt_q != '0) begin
      rem_q <= ge ? rs - {1'b0, den} : rs;
      q_q   <= {q_q[38:0], ge};
      dvd_q <= dvd_q << 1;
    end
    if (cmd_i.load_out) begin
      err_q <= eo_ext[15:0];
    end
  end

  assign status_o.adaptive = (cfg_i.mode == MODE_NLMS) || (cfg_i.mode == MODE_LMS);
  assign status_o.plain    = (cfg_i.mode == MODE_LMS);
  assign status_o.div_busy = (dcnt_q != '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign error_out_o = err_q;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output beat overwritten while stalled");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> dcnt_q == '0) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

@@ design/leaky_nlms_adaptive_filter.sv @@
// Leaky NLMS adaptive FIR filter, top level: configuration registers,
// sequencer and datapath. Uses lnf_pkg, lnf_ctrl, lnf_dp.
//
// Input beats carry op_i and sample_in_i on in_valid_i/in_stall_o; a sample
// beat in an adaptive mode yields one error_out_o beat on out_valid_o and
// out_stall_i, a clear beat zeroes the coefficients and yields nothing.
// In pass-through mode the sample is returned unchanged.
// One beat is worked on at a time. Adaptive beats run a filter pass that
// reads, multiplies and accumulates each tap, one error step, then an
// update pass that reads, multiplies twice and writes each tap in plain
// LMS, and in leaky NLMS also starts and waits on a one-bit-per-cycle
// divider that forms each normalized correction.
// The finished result sits in an output register, so a new input beat is
// taken while it waits; a stalled receiver holds later results back.
// Reset clears the tap line, coefficients, write pointer and output valid
// and loads the default configuration. The user must write cfg_we_i/
// cfg_index_i/cfg_data_i only while idle; the block does not enforce it.
`default_nettype none
module leaky_nlms_adaptive_filter import lnf_pkg::*; #(
  parameter int TAPS = 32,
  parameter int DELAY = 1,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] error_out_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int TW = $clog2(TAPS);

  lnf_cfg_t      cfg_q;
  lnf_cmd_t      cmd;
  lnf_status_t   status;
  logic [TW-1:0] idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= RST_MODE;
      cfg_q.step_size   <= RST_STEP;
      cfg_q.regularizer <= RST_REGUL;
      cfg_q.leak_factor <= RST_LEAK;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:  cfg_q.mode        <= cfg_data_i[1:0];
        REG_STEP:  cfg_q.step_size   <= cfg_data_i[5:0];
        REG_REGUL: cfg_q.regularizer <= cfg_data_i;
        REG_LEAK:  cfg_q.leak_factor <= cfg_data_i;
        default:   cfg_q.mode        <= cfg_q.mode;
      endcase
    end
  end

  lnf_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  lnf_dp #(.TAPS(TAPS), .DELAY(DELAY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .cfg_i       (cfg_q),
    .sample_i    (sample_in_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .error_out_o (error_out_o)
  );

endmodule
`default_nettype wire
